// ----- design/mdk_pkg.sv -----
`default_nettype none

package mdk_pkg;

    localparam int DutyWidth   = 8;
    localparam int KickWidth   = 10;
    localparam int TickWidth   = 8;
    localparam int PeriodWidth = 16;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDatWidth = 16;
    localparam int ProdWidth   = PeriodWidth + TickWidth;

    localparam logic [DutyWidth-1:0]   KickDutyRst       = 8'd160;
    localparam logic [KickWidth-1:0]   KickTicksRst      = 10'd100;
    localparam logic [TickWidth-1:0]   TickMsRst         = 8'd10;
    localparam logic [PeriodWidth-1:0] BlinkPeriodRst    = 16'd1000;
    localparam logic [PeriodWidth-1:0] HaltBlinkRst      = 16'd100;
    localparam logic [PeriodWidth-1:0] BlinkCountMax     = 16'hFFFF;

    localparam logic [CfgIdxWidth-1:0] REG_KICK_DUTY         = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_KICK_TICKS        = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_TICK_MS           = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_BLINK_PERIOD_MS   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_HALT_BLINK_PERIOD = 3'd4;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_DRIVE = 2'd1,
        FUNC_HALT  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        GEAR_FREE    = 2'd0,
        GEAR_FORWARD = 2'd1,
        GEAR_REVERSE = 2'd2,
        GEAR_BRAKE   = 2'd3
    } gear_t;

    typedef struct packed {
        logic [DutyWidth-1:0]   kick_duty;
        logic [KickWidth-1:0]   kick_ticks;
        logic [TickWidth-1:0]   tick_ms;
        logic [PeriodWidth-1:0] blink_period_ms;
        logic [PeriodWidth-1:0] halt_blink_period_ms;
    } cfg_t;

    typedef struct packed {
        func_t                func;
        gear_t                gear;
        logic [DutyWidth-1:0] duty;
    } item_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    typedef struct packed {
        logic halted;
        logic kick_active;
    } status_t;

endpackage

`default_nettype wire

// ----- design/mdk_cfg_regs.sv -----
`default_nettype none

module mdk_cfg_regs
    import mdk_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [CfgDatWidth-1:0] cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_KICK_DUTY:         cfg_next.kick_duty = cfg_data[DutyWidth-1:0];
                REG_KICK_TICKS:        cfg_next.kick_ticks = cfg_data[KickWidth-1:0];
                REG_TICK_MS:           cfg_next.tick_ms = cfg_data[TickWidth-1:0];
                REG_BLINK_PERIOD_MS:   cfg_next.blink_period_ms = cfg_data[PeriodWidth-1:0];
                REG_HALT_BLINK_PERIOD: cfg_next.halt_blink_period_ms =
                                           cfg_data[PeriodWidth-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kick_duty            <= KickDutyRst;
            cfg_reg.kick_ticks           <= KickTicksRst;
            cfg_reg.tick_ms              <= TickMsRst;
            cfg_reg.blink_period_ms      <= BlinkPeriodRst;
            cfg_reg.halt_blink_period_ms <= HaltBlinkRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/mdk_in_reg.sv -----
`default_nettype none

module mdk_in_reg
    import mdk_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t in_item,
    input  wire logic  advance,
    output stage_ctl_t ctl,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

`default_nettype wire

// ----- design/mdk_engine.sv -----
`default_nettype none

module mdk_engine
    import mdk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 item_valid,
    input  wire item_t                item,
    output logic                      advance,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [DutyWidth-1:0]      pwm_fwd,
    output logic [DutyWidth-1:0]      pwm_rev,
    output logic                      led_on,
    output logic                      is_halted,
    output status_t                   status
);

    logic [DutyWidth-1:0]   held_duty_reg,   held_duty_next;
    gear_t                  held_gear_reg,   held_gear_next;
    logic [KickWidth-1:0]   kick_left_reg,   kick_left_next;
    logic [PeriodWidth-1:0] blink_count_reg, blink_count_next;
    logic                   led_level_reg,   led_level_next;
    logic                   halted_reg,      halted_next;

    logic                   out_valid_reg,   out_valid_next;
    logic [DutyWidth-1:0]   fwd_reg,         fwd_next;
    logic [DutyWidth-1:0]   rev_reg,         rev_next;
    logic                   led_reg,         led_next;
    logic                   hlt_reg,         hlt_next;

    logic                   fire;
    logic                   emit;
    logic [PeriodWidth-1:0] count_inc;
    logic [PeriodWidth-1:0] period;
    logic [ProdWidth-1:0]   elapsed;
    logic                   toggle;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = item_valid && advance;
    assign count_inc = (blink_count_reg == BlinkCountMax) ? blink_count_reg
                                                          : blink_count_reg + 1'b1;
    assign period    = halted_reg ? cfg.halt_blink_period_ms : cfg.blink_period_ms;
    assign elapsed   = ProdWidth'(count_inc) * ProdWidth'(cfg.tick_ms);
    assign toggle    = elapsed > ProdWidth'(period[PeriodWidth-1:1]);

    always_comb
    begin
        logic [DutyWidth-1:0] run_duty;
        held_duty_next   = held_duty_reg;
        held_gear_next   = held_gear_reg;
        kick_left_next   = kick_left_reg;
        blink_count_next = blink_count_reg;
        led_level_next   = led_level_reg;
        halted_next      = halted_reg;
        emit             = 1'b0;
        fwd_next         = '0;
        rev_next         = '0;
        led_next         = led_level_reg;
        hlt_next         = halted_reg;
        run_duty         = (kick_left_reg != '0) ? cfg.kick_duty : held_duty_reg;
        if (fire)
        begin
            case (item.func)
                FUNC_DRIVE:
                begin
                    if (!halted_reg)
                    begin
                        if (held_duty_reg == '0 || held_gear_reg == GEAR_FREE ||
                            held_gear_reg == GEAR_BRAKE)
                        begin
                            kick_left_next = cfg.kick_ticks;
                        end
                        if (item.duty > cfg.kick_duty)
                        begin
                            kick_left_next = '0;
                        end
                        held_duty_next = item.duty;
                        held_gear_next = item.gear;
                    end
                end
                FUNC_HALT:
                begin
                    halted_next = 1'b1;
                    emit        = 1'b1;
                    hlt_next    = 1'b1;
                end
                FUNC_TICK:
                begin
                    emit             = 1'b1;
                    blink_count_next = toggle ? '0 : count_inc;
                    led_level_next   = led_level_reg ^ toggle;
                    led_next         = led_level_reg ^ toggle;
                    if (!halted_reg)
                    begin
                        case (held_gear_reg)
                            GEAR_FORWARD: fwd_next = run_duty;
                            GEAR_REVERSE: rev_next = run_duty;
                            GEAR_BRAKE:
                            begin
                                fwd_next = held_duty_reg;
                                rev_next = held_duty_reg;
                            end
                            default: ;
                        endcase
                        if (kick_left_reg != '0)
                        begin
                            kick_left_next = kick_left_reg - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_duty_reg   <= '0;
            held_gear_reg   <= GEAR_FREE;
            kick_left_reg   <= '0;
            blink_count_reg <= '0;
            led_level_reg   <= 1'b1;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            held_duty_reg   <= held_duty_next;
            held_gear_reg   <= held_gear_next;
            kick_left_reg   <= kick_left_next;
            blink_count_reg <= blink_count_next;
            led_level_reg   <= led_level_next;
            halted_reg      <= halted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            led_reg <= led_next;
            hlt_reg <= hlt_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pwm_fwd            = fwd_reg;
    assign pwm_rev            = rev_reg;
    assign led_on             = led_reg;
    assign is_halted          = hlt_reg;
    assign status.halted      = halted_reg;
    assign status.kick_active = kick_left_reg != '0;

endmodule

`default_nettype wire

// ----- design/motor_drive_kickstart_controller_top.sv -----
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid, in_stall, func, gear, duty      | into block
// out      | out_valid, out_stall, pwm_fwd, pwm_rev,   | out of block
//          | led_on, is_halted                         |
// cfg      | cfg_wr_en, cfg_index, cfg_data            | into block
//
// One item per cycle sustained while the output is not stalled; each item
// goes through the input register, then the state update into the result register.
// Drive commands and unused kinds give no result.
// Reset: gear free, duty and kick count zero, LED on, not halted.
// An output stall holds the result and stalls the input once the input
// register is also full.
`default_nettype none

module motor_drive_kickstart_controller_top
    import mdk_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             func,
    input  wire logic [1:0]             gear,
    input  wire logic [DutyWidth-1:0]   duty,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [DutyWidth-1:0]        pwm_fwd,
    output logic [DutyWidth-1:0]        pwm_rev,
    output logic                        led_on,
    output logic                        is_halted,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [CfgDatWidth-1:0] cfg_data
);

    cfg_t       cfg;
    item_t      in_item;
    item_t      item;
    stage_ctl_t ctl;
    status_t    status;
    logic       advance;

    assign in_item.func = func_t'(func);
    assign in_item.gear = gear_t'(gear);
    assign in_item.duty = duty;

    mdk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdk_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .advance  (advance),
        .ctl      (ctl),
        .item     (item)
    );

    mdk_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (ctl.valid),
        .item       (item),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pwm_fwd    (pwm_fwd),
        .pwm_rev    (pwm_rev),
        .led_on     (led_on),
        .is_halted  (is_halted),
        .status     (status)
    );

`ifndef SYNTHESIS
    a_halt_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_halted |-> pwm_fwd == '0 && pwm_rev == '0)
        else $error("halted result carries non-zero duty");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.halted |=> status.halted)
        else $error("halt state cleared");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid && out_valid && out_stall |-> in_stall)
        else $error("input transfer taken while both stages blocked");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.valid |-> !in_stall && ctl.advance == advance)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

// ----- verif/mdk_drive_checker.sv -----
`timescale 1ns / 1ps

module mdk_drive_checker
    import mdk_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [1:0]             func,
    input  wire logic [1:0]             gear,
    input  wire logic [DutyWidth-1:0]   duty,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [DutyWidth-1:0]   pwm_fwd,
    input  wire logic [DutyWidth-1:0]   pwm_rev,
    input  wire logic                   led_on,
    input  wire logic                   is_halted,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [CfgDatWidth-1:0] cfg_data,
    output int                          mismatches,
    output int                          pending
);

    typedef struct packed {
        logic [DutyWidth-1:0] fwd;
        logic [DutyWidth-1:0] rev;
        logic                 led;
        logic                 halted;
    } bridge_out_t;

    bridge_out_t bridge_due[$];

    logic [DutyWidth-1:0]   kick_duty;
    logic [KickWidth-1:0]   kick_ticks;
    logic [TickWidth-1:0]   tick_ms;
    logic [PeriodWidth-1:0] run_period;
    logic [PeriodWidth-1:0] halt_period;

    logic [DutyWidth-1:0]   held_duty;
    gear_t                  held_gear;
    logic [KickWidth-1:0]   kick_left;
    logic [PeriodWidth-1:0] blink_count;
    logic                   led_level;
    logic                   halted;

    task automatic write_setting(input logic [CfgIdxWidth-1:0] idx,
                                 input logic [CfgDatWidth-1:0] data);
        case (idx)
            REG_KICK_DUTY:         kick_duty   = data[DutyWidth-1:0];
            REG_KICK_TICKS:        kick_ticks  = data[KickWidth-1:0];
            REG_TICK_MS:           tick_ms     = data[TickWidth-1:0];
            REG_BLINK_PERIOD_MS:   run_period  = data;
            REG_HALT_BLINK_PERIOD: halt_period = data;
            default: ;
        endcase
    endtask

    task automatic step_bridge(input logic [1:0] f, input logic [1:0] g,
                               input logic [DutyWidth-1:0] d);
        bridge_out_t            r;
        logic [DutyWidth-1:0]   use_duty;
        logic [PeriodWidth-1:0] period;
        logic [ProdWidth-1:0]   elapsed;
        r = '0;
        case (f)
            FUNC_DRIVE:
            begin
                if (!halted)
                begin
                    if (held_duty == '0 || held_gear == GEAR_FREE || held_gear == GEAR_BRAKE)
                        kick_left = kick_ticks;
                    if (d > kick_duty)
                        kick_left = '0;
                    held_duty = d;
                    held_gear = gear_t'(g);
                end
            end
            FUNC_HALT:
            begin
                halted   = 1'b1;
                r.led    = led_level;
                r.halted = 1'b1;
                bridge_due.push_back(r);
            end
            FUNC_TICK:
            begin
                period = halted ? halt_period : run_period;
                if (blink_count != BlinkCountMax)
                    blink_count = blink_count + 1'b1;
                elapsed = blink_count * tick_ms;
                if (elapsed > (period >> 1))
                begin
                    led_level   = ~led_level;
                    blink_count = '0;
                end
                if (!halted)
                begin
                    use_duty = (kick_left != '0) ? kick_duty : held_duty;
                    case (held_gear)
                        GEAR_FORWARD: r.fwd = use_duty;
                        GEAR_REVERSE: r.rev = use_duty;
                        GEAR_BRAKE:
                        begin
                            r.fwd = held_duty;
                            r.rev = held_duty;
                        end
                        default: ;
                    endcase
                    if (kick_left != '0)
                        kick_left = kick_left - 1'b1;
                end
                r.led    = led_level;
                r.halted = halted;
                bridge_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_bridge();
        bridge_out_t e;
        if (bridge_due.size() == 0)
        begin
            $error("result transfer with nothing expected");
            mismatches++;
        end
        else
        begin
            e = bridge_due.pop_front();
            if (pwm_fwd !== e.fwd)
            begin
                $error("pwm_fwd: expected %0d, got %0d", e.fwd, pwm_fwd);
                mismatches++;
            end
            if (pwm_rev !== e.rev)
            begin
                $error("pwm_rev: expected %0d, got %0d", e.rev, pwm_rev);
                mismatches++;
            end
            if (led_on !== e.led)
            begin
                $error("led_on: expected %0d, got %0d", e.led, led_on);
                mismatches++;
            end
            if (is_halted !== e.halted)
            begin
                $error("is_halted: expected %0d, got %0d", e.halted, is_halted);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_duty   = KickDutyRst;
            kick_ticks  = KickTicksRst;
            tick_ms     = TickMsRst;
            run_period  = BlinkPeriodRst;
            halt_period = HaltBlinkRst;
            held_duty   = '0;
            held_gear   = GEAR_FREE;
            kick_left   = '0;
            blink_count = '0;
            led_level   = 1'b1;
            halted      = 1'b0;
            bridge_due.delete();
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_wr_en)
                write_setting(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                check_bridge();
            if (in_valid && !in_stall)
                step_bridge(func, gear, duty);
            pending = bridge_due.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import mdk_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int         CycleLimit = 1_000_000;
    localparam int         HoldCycles = 300;
    localparam int         SoakTicks  = 150;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             func;
    logic [1:0]             gear;
    logic [DutyWidth-1:0]   duty;
    logic                   out_valid;
    logic                   out_stall;
    logic [DutyWidth-1:0]   pwm_fwd;
    logic [DutyWidth-1:0]   pwm_rev;
    logic                   led_on;
    logic                   is_halted;
    logic                   cfg_wr_en;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgDatWidth-1:0] cfg_data;

    int                     mismatches;
    int                     pending;
    int                     cycle_count;
    bit                     idle_on;
    bit                     hold_req;
    logic [DutyWidth-1:0]   cur_kick;

    motor_drive_kickstart_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .gear      (gear),
        .duty      (duty),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pwm_fwd   (pwm_fwd),
        .pwm_rev   (pwm_rev),
        .led_on    (led_on),
        .is_halted (is_halted),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mdk_drive_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .gear       (gear),
        .duty       (duty),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pwm_fwd    (pwm_fwd),
        .pwm_rev    (pwm_rev),
        .led_on     (led_on),
        .is_halted  (is_halted),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CycleLimit)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HoldCycles - 1) @(negedge clk);
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 20);
        end
    end

    task automatic push_item(input logic [1:0] f, input logic [1:0] g,
                             input logic [DutyWidth-1:0] d);
        while (idle_on && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        gear     <= g;
        duty     <= d;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic push_random(input bit with_halt);
        int                   pick;
        logic [DutyWidth-1:0] d;
        logic [1:0]           g;
        pick = $urandom_range(99);
        g    = 2'($urandom_range(3));
        case ($urandom_range(4))
            0:       d = '0;
            1:       d = '1;
            2:       d = cur_kick;
            3:       d = cur_kick + 1'b1;
            default: d = DutyWidth'($urandom_range(255));
        endcase
        if (pick < 55)
            push_item(FUNC_TICK, g, d);
        else if (pick < 90)
            push_item(FUNC_DRIVE, g, d);
        else if (pick < 95 || !with_halt)
            push_item(FUNC_SPARE, g, d);
        else
            push_item(FUNC_HALT, g, d);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDatWidth-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // upper data bits of the narrow registers carry junk on purpose
    task automatic load_settings(input logic [DutyWidth-1:0]   kd,
                                 input logic [KickWidth-1:0]   kt,
                                 input logic [TickWidth-1:0]   tm,
                                 input logic [PeriodWidth-1:0] bp,
                                 input logic [PeriodWidth-1:0] hp);
        write_reg(REG_KICK_DUTY, {8'($urandom_range(255)), kd});
        write_reg(REG_KICK_TICKS, {6'($urandom_range(63)), kt});
        write_reg(REG_TICK_MS, {8'($urandom_range(255)), tm});
        write_reg(REG_BLINK_PERIOD_MS, bp);
        write_reg(REG_HALT_BLINK_PERIOD, hp);
        write_reg(REG_HALT_BLINK_PERIOD + CfgIdxWidth'(1 + $urandom_range(2)),
                  CfgDatWidth'($urandom_range(65535)));
        cfg_wr_en <= 1'b0;
        cur_kick = kd;
    endtask

    task automatic load_random_settings();
        load_settings(DutyWidth'($urandom_range(255)),
                      KickWidth'($urandom_range(99) < 90 ? $urandom_range(40)
                                                         : $urandom_range(1023)),
                      TickWidth'($urandom_range(1, 255)),
                      PeriodWidth'($urandom_range(1) ? $urandom_range(4000)
                                                     : $urandom_range(65535)),
                      PeriodWidth'($urandom_range(1) ? $urandom_range(4000)
                                                     : $urandom_range(65535)));
    endtask

    // drive commands leave nothing to wait for, so allow for the pipeline
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_run(input int count, input bit with_halt);
        repeat (count) push_random(with_halt);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_TICK;
        gear      = GEAR_FREE;
        duty      = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        cur_kick  = KickDutyRst;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: kick arming, cancelling, threshold, each gear
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_DRIVE, GEAR_FORWARD, 8'd100);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_DRIVE, GEAR_REVERSE, 8'hFF);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_DRIVE, GEAR_BRAKE, 8'h55);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_DRIVE, GEAR_FORWARD, 8'hAA);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_DRIVE, GEAR_FREE, 8'h00);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_SPARE, GEAR_BRAKE, 8'hFF);
        push_item(FUNC_DRIVE, GEAR_FORWARD, 8'd1);
        push_item(FUNC_TICK, GEAR_BRAKE, 8'hFF);
        push_item(FUNC_DRIVE, GEAR_REVERSE, KickDutyRst);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        random_run(100, 1'b0);
        drain();

        // LED toggles every tick, kick never lasts
        load_settings('0, '0, 8'd1, '0, '0);
        random_run(200, 1'b0);
        drain();

        load_settings('1, '1, '1, '1, '1);
        random_run(200, 1'b0);
        drain();

        // long receiver hold-off so the block backs up into its input
        load_random_settings();
        hold_req = 1'b1;
        random_run(200, 1'b0);
        drain();

        // zero tick length: LED frozen
        idle_on = 1'b0;
        load_settings(8'd90, 10'd5, '0, 16'd1000, 16'd100);
        push_item(FUNC_DRIVE, GEAR_FORWARD, 8'd50);
        repeat (SoakTicks)
            push_item(FUNC_TICK, 2'($urandom_range(3)), DutyWidth'($urandom_range(255)));
        drain();
        idle_on = 1'b1;

        load_settings(DutyWidth'($urandom_range(255)), 10'd7, 8'd1, 16'd1000, 16'd300);
        random_run(200, 1'b0);
        drain();

        // halt is permanent, so it comes last
        load_random_settings();
        push_item(FUNC_DRIVE, GEAR_FORWARD, 8'd200);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_HALT, GEAR_FREE, 8'h00);
        push_item(FUNC_HALT, GEAR_BRAKE, 8'hFF);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_DRIVE, GEAR_REVERSE, 8'd30);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        push_item(FUNC_SPARE, GEAR_FREE, 8'h00);
        push_item(FUNC_TICK, GEAR_FREE, 8'h00);
        random_run(200, 1'b1);
        drain();

        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mdk_pkg.sv
design/mdk_cfg_regs.sv
design/mdk_in_reg.sv
design/mdk_engine.sv
design/motor_drive_kickstart_controller_top.sv
verif/mdk_drive_checker.sv
verif/testbench.sv
